// ===== hdl/fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsd_pkg
// shared types and constants of the fifo slot dispatcher
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int QUEUE_DEPTH = 64;

    localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int JOB_W  = 16;
    localparam int DUR_W  = 24;
    localparam int TICK_W = 32;
    localparam int QENT_W = JOB_W + DUR_W + TICK_W;

    localparam logic [DUR_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [JOB_W-1:0] COMPLETED_MAX = '1;

    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_SUMMARY  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic CFG_SLOTS_IN_USE = 1'b0;
    localparam logic CFG_JOB_LIMIT    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVF,
        ST_DISP,
        ST_DLOAD,
        ST_ADV,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic accept;
        logic arr_write;
        logic ovf_emit;
        logic idx_clr;
        logic idx_inc;
        logic disp_load;
        logic snap_busy;
        logic adv_step;
        logic sum_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic run_done;
        logic q_full;
        logic disp_end;
        logic disp_take;
        logic adv_end;
        logic adv_emit;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/fifo_slot_dispatcher.sv =====
// ----------------------------------------------------------------------------
// fifo_slot_dispatcher
// fifo job dispatcher feeding parallel execution slots, time in whole ticks
// ----------------------------------------------------------------------------
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+-----------------------
//  s_       | s_valid s_ready s_cmd s_job_id ...      | arrival or tick word
//  m_       | m_valid m_ready m_kind ... m_last       | start/complete/summary
//  cfg_     | cfg_valid cfg_ready cfg_addr cfg_data   | register write
//
//  one word at a time: an arrival is handled in ST_IDLE, an overflow also goes through ST_OVF
//  a tick walks the active slots in ST_DISP, with an ST_DLOAD step per start for the
//  queue ram read, then walks all SLOT_COUNT slots in ST_ADV and ends in ST_SUM; the
//  walk is cut short when the run ends inside the tick
//  a full output register holds the sequencer in place until m_ready
//  reset is synchronous, active low; the queue ram needs no clearing
// ----------------------------------------------------------------------------
module fifo_slot_dispatcher
    import fsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // config write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_addr,
    input  logic [15:0]       cfg_data,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [JOB_W-1:0]  s_job_id,
    input  logic [DUR_W-1:0]  s_duration,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [JOB_W-1:0]  m_out_job,
    output logic [2:0]        m_slot,
    output logic [TICK_W-1:0] m_wait_ticks,
    output logic [3:0]        m_busy_slots,
    output logic              m_done_res,
    output logic              m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // registers take a write on any cycle
    assign cfg_ready = 1'b1;

    fsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .cmd     (cmd)
    );

    fsd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_job_id     (s_job_id),
        .s_duration   (s_duration),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_job    (m_out_job),
        .m_slot       (m_slot),
        .m_wait_ticks (m_wait_ticks),
        .m_busy_slots (m_busy_slots),
        .m_done_res   (m_done_res),
        .m_last       (m_last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== hdl/fsd_ram.sv =====
// ----------------------------------------------------------------------------
// fsd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/fsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsd_ctrl
// sequencer that walks the slots for dispatch and advance on every tick
// ----------------------------------------------------------------------------
module fsd_ctrl
    import fsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!status.run_done) begin
                        if (s_cmd == CMD_ARRIVAL) begin
                            if (status.q_full) begin
                                state_next = ST_OVF;
                            end else begin
                                cmd.arr_write = 1'b1;
                            end
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_DISP;
                        end
                    end
                end
            end
            ST_OVF: begin
                if (status.out_free) begin
                    cmd.ovf_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DISP: begin
                if (status.disp_end) begin
                    cmd.idx_clr   = 1'b1;
                    cmd.snap_busy = 1'b1;
                    state_next    = ST_ADV;
                end else if (status.disp_take) begin
                    state_next = ST_DLOAD;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DLOAD: begin
                if (status.out_free) begin
                    cmd.disp_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = ST_DISP;
                end
            end
            ST_ADV: begin
                if (status.run_done || status.adv_end) begin
                    state_next = ST_SUM;
                end else if (!status.adv_emit || status.out_free) begin
                    cmd.adv_step = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            ST_SUM: begin
                if (status.out_free) begin
                    cmd.sum_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/fsd_datapath.sv =====
// ----------------------------------------------------------------------------
// fsd_datapath
// wait queue, slot registers, counters, config and output register
// ----------------------------------------------------------------------------
module fsd_datapath
    import fsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_addr,
    input  logic [15:0]       cfg_data,
    input  logic [JOB_W-1:0]  s_job_id,
    input  logic [DUR_W-1:0]  s_duration,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [JOB_W-1:0]  m_out_job,
    output logic [2:0]        m_slot,
    output logic [TICK_W-1:0] m_wait_ticks,
    output logic [3:0]        m_busy_slots,
    output logic              m_done_res,
    output logic              m_last,
    input  dp_cmd_t           cmd,
    output dp_status_t        status
);

    logic [3:0]        slots_in_use_reg;
    logic [JOB_W-1:0]  job_limit_reg;

    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QCNT_W-1:0] qcount_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [JOB_W-1:0]  completed_reg;
    logic              done_reg;

    logic [SLOT_COUNT-1:0] busy_reg;
    logic [JOB_W-1:0]      sjob_reg [SLOT_COUNT];
    logic [DUR_W-1:0]      sdur_reg [SLOT_COUNT];
    logic [DUR_W-1:0]      selap_reg [SLOT_COUNT];

    logic [SLOT_CNT_W-1:0] idx_reg;
    logic [SLOT_CNT_W-1:0] busy_snap_reg;
    logic [JOB_W-1:0]      ovf_job_reg;

    logic              mv_reg;
    kind_t             kind_reg;
    logic [JOB_W-1:0]  job_o_reg;
    logic [2:0]        slot_o_reg;
    logic [TICK_W-1:0] wait_o_reg;
    logic [3:0]        busy_o_reg;
    logic              done_o_reg;
    logic              last_o_reg;

    logic [QENT_W-1:0]     q_rd;
    logic [JOB_W-1:0]      q_job;
    logic [DUR_W-1:0]      q_dur;
    logic [TICK_W-1:0]     q_arr;
    logic [SLOT_IDX_W-1:0] sidx;
    logic [SLOT_CNT_W-1:0] active;
    logic [SLOT_CNT_W-1:0] busy_cnt;
    logic [DUR_W-1:0]      elap_new;
    logic                  completes;
    logic [JOB_W-1:0]      comp_new;
    logic                  out_free;

    fsd_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (cmd.arr_write),
        .wr_addr (tail_reg),
        .wr_data ({s_job_id, s_duration, tick_reg}),
        .rd_addr (head_reg),
        .rd_data (q_rd)
    );

    assign {q_job, q_dur, q_arr} = q_rd;
    assign sidx = SLOT_IDX_W'(idx_reg);

    always_comb begin
        if (32'(slots_in_use_reg) > SLOT_COUNT) begin
            active = SLOT_CNT_W'(SLOT_COUNT);
        end else begin
            active = SLOT_CNT_W'(slots_in_use_reg);
        end
        busy_cnt = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_cnt = busy_cnt + SLOT_CNT_W'(busy_reg[i]);
        end
    end

    // saturating elapsed count and completion test for the walked slot
    assign elap_new  = (selap_reg[sidx] == ELAPSED_MAX) ? ELAPSED_MAX
                                                         : selap_reg[sidx] + 1'b1;
    assign completes = busy_reg[sidx] && (elap_new >= sdur_reg[sidx]);
    assign comp_new  = (completed_reg == COMPLETED_MAX) ? COMPLETED_MAX
                                                        : completed_reg + 1'b1;
    assign out_free  = !mv_reg || m_ready;

    assign status.run_done  = done_reg;
    assign status.q_full    = (qcount_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.disp_end  = (idx_reg >= active);
    assign status.disp_take = !busy_reg[sidx] && (qcount_reg != '0);
    assign status.adv_end   = (idx_reg == SLOT_CNT_W'(SLOT_COUNT));
    assign status.adv_emit  = completes;
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= 4'(SLOT_COUNT);
            job_limit_reg    <= 16'd80;
            head_reg         <= '0;
            tail_reg         <= '0;
            qcount_reg       <= '0;
            tick_reg         <= '0;
            completed_reg    <= '0;
            done_reg         <= 1'b0;
            busy_reg         <= '0;
            idx_reg          <= '0;
            mv_reg           <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[3:0];
                    CFG_JOB_LIMIT:    job_limit_reg    <= cfg_data;
                    default:          ;
                endcase
            end

            if (cmd.arr_write) begin
                tail_reg   <= (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                qcount_reg <= qcount_reg + 1'b1;
            end

            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.disp_load) begin
                busy_reg[sidx] <= 1'b1;
                head_reg   <= (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                qcount_reg <= qcount_reg - 1'b1;
            end

            if (cmd.adv_step && completes) begin
                busy_reg[sidx] <= 1'b0;
                completed_reg  <= comp_new;
                if (comp_new >= job_limit_reg) begin
                    done_reg <= 1'b1;
                end
            end

            if (cmd.sum_emit && !done_reg) begin
                tick_reg <= tick_reg + 1'b1;
            end

            if (cmd.ovf_emit || cmd.disp_load || cmd.sum_emit
                    || (cmd.adv_step && completes)) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ovf_job_reg <= s_job_id;
        end
        if (cmd.snap_busy) begin
            busy_snap_reg <= busy_cnt;
        end
        if (cmd.disp_load) begin
            sjob_reg[sidx]  <= q_job;
            sdur_reg[sidx]  <= q_dur;
            selap_reg[sidx] <= '0;
        end
        if (cmd.adv_step && busy_reg[sidx]) begin
            selap_reg[sidx] <= elap_new;
        end

        if (cmd.ovf_emit) begin
            kind_reg   <= KIND_OVERFLOW;
            job_o_reg  <= ovf_job_reg;
            slot_o_reg <= '0;
            wait_o_reg <= '0;
            busy_o_reg <= '0;
            done_o_reg <= done_reg;
            last_o_reg <= 1'b1;
        end else if (cmd.disp_load) begin
            kind_reg   <= KIND_START;
            job_o_reg  <= q_job;
            slot_o_reg <= 3'(idx_reg);
            wait_o_reg <= tick_reg - q_arr;
            busy_o_reg <= '0;
            done_o_reg <= done_reg;
            last_o_reg <= 1'b0;
        end else if (cmd.adv_step && completes) begin
            kind_reg   <= KIND_COMPLETE;
            job_o_reg  <= sjob_reg[sidx];
            slot_o_reg <= 3'(idx_reg);
            wait_o_reg <= '0;
            busy_o_reg <= '0;
            done_o_reg <= done_reg || (comp_new >= job_limit_reg);
            last_o_reg <= 1'b0;
        end else if (cmd.sum_emit) begin
            kind_reg   <= KIND_SUMMARY;
            job_o_reg  <= '0;
            slot_o_reg <= '0;
            wait_o_reg <= '0;
            busy_o_reg <= 4'(busy_snap_reg);
            done_o_reg <= done_reg;
            last_o_reg <= 1'b1;
        end
    end

    assign m_valid      = mv_reg;
    assign m_kind       = kind_reg;
    assign m_out_job    = job_o_reg;
    assign m_slot       = slot_o_reg;
    assign m_wait_ticks = wait_o_reg;
    assign m_busy_slots = busy_o_reg;
    assign m_done_res   = done_o_reg;
    assign m_last       = last_o_reg;

endmodule

// ===== hdl/fsd_checker.sv =====
// ----------------------------------------------------------------------------
// fsd_checker
// port level checks of the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module fsd_checker
    import fsd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_kind,
    input logic [2:0]        m_slot,
    input logic [TICK_W-1:0] m_wait_ticks,
    input logic              m_done_res,
    input logic              m_last
);

    // stalled result word stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped under stall");

    a_sum_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_SUMMARY || m_kind == KIND_OVERFLOW) |-> m_last)
        else $error("summary or overflow word not last");

    a_start_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_START |-> !m_done_res && !m_last)
        else $error("start word after run end or marked last");

    a_ovf_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_OVERFLOW |-> m_slot == 3'd0 && m_wait_ticks == '0)
        else $error("overflow word carries slot or wait");

endmodule

bind fifo_slot_dispatcher fsd_checker u_fsd_checker (.*);

// ===== tb/fifo_slot_dispatcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_slot_dispatcher_tb
// self-checking bench: drives arrival and tick words with random gaps and
// output stalls, predicts every start, completion, summary and overflow word
// from a private model of queue and slots, and checks them in order
// ----------------------------------------------------------------------------
module fifo_slot_dispatcher_tb;
    import fsd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 40;     // well above one tick of the block
    localparam int LONG_STALL  = 400;

    typedef struct packed {
        logic              cmd;
        logic [JOB_W-1:0]  id;
        logic [DUR_W-1:0]  dur;
    } in_word_t;

    typedef struct packed {
        kind_t             kind;
        logic [JOB_W-1:0]  job;
        logic [2:0]        slot;
        logic [TICK_W-1:0] wt;
        logic [3:0]        busy;
        logic              done;
        logic              last;
    } res_word_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_addr;
    logic [15:0]       cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_cmd;
    logic [JOB_W-1:0]  s_job_id;
    logic [DUR_W-1:0]  s_duration;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_kind;
    logic [JOB_W-1:0]  m_out_job;
    logic [2:0]        m_slot;
    logic [TICK_W-1:0] m_wait_ticks;
    logic [3:0]        m_busy_slots;
    logic              m_done_res;
    logic              m_last;

    fifo_slot_dispatcher u_dut (.*);

    // word streams and bookkeeping
    in_word_t  send_q[$];
    res_word_t want_q[$];
    int        errors;
    int        cycles;
    logic      quiet;        // no idling on either side while set
    logic      stall_req;    // asks the receiver for one long hold-off
    bit        in_taken;

    // private copy of the dispatcher state
    logic [JOB_W-1:0]  pq_job  [QUEUE_DEPTH];
    logic [DUR_W-1:0]  pq_dur  [QUEUE_DEPTH];
    logic [TICK_W-1:0] pq_tick [QUEUE_DEPTH];
    int                pq_head, pq_tail, pq_count;
    logic              sl_busy [SLOT_COUNT];
    logic [JOB_W-1:0]  sl_job  [SLOT_COUNT];
    logic [DUR_W-1:0]  sl_dur  [SLOT_COUNT];
    logic [DUR_W-1:0]  sl_age  [SLOT_COUNT];
    logic [TICK_W-1:0] now_tick;
    logic [JOB_W-1:0]  done_jobs;
    logic              run_over;
    logic [3:0]        slots_cfg;
    logic [15:0]       limit_cfg;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fifo_slot_dispatcher_tb: errors");
            $finish;
        end
    end

    function automatic void post(kind_t k, logic [JOB_W-1:0] job, int s,
                                 logic [TICK_W-1:0] wt, int busy);
        res_word_t r;
        r.kind = k;
        r.job  = job;
        r.slot = s[2:0];
        r.wt   = wt;
        r.busy = busy[3:0];
        r.done = run_over;
        r.last = 1'b0;
        want_q.insert(want_q.size(), r);
    endfunction

    // expected words of one accepted input word
    function automatic void dispatch_word(in_word_t w);
        int active;
        int busy;
        if (run_over)
            return;
        if (w.cmd == CMD_ARRIVAL) begin
            if (pq_count >= QUEUE_DEPTH) begin
                post(KIND_OVERFLOW, w.id, 0, '0, 0);
                want_q[$].last = 1'b1;
                return;
            end
            pq_job[pq_tail]  = w.id;
            pq_dur[pq_tail]  = w.dur;
            pq_tick[pq_tail] = now_tick;
            pq_tail  = (pq_tail + 1) % QUEUE_DEPTH;
            pq_count = pq_count + 1;
            return;
        end
        // tick: fill empty slots in order
        active = (slots_cfg > SLOT_COUNT) ? SLOT_COUNT : slots_cfg;
        for (int s = 0; s < active; s++) begin
            if (!sl_busy[s] && pq_count > 0) begin
                sl_busy[s] = 1'b1;
                sl_job[s]  = pq_job[pq_head];
                sl_dur[s]  = pq_dur[pq_head];
                sl_age[s]  = '0;
                post(KIND_START, sl_job[s], s, now_tick - pq_tick[pq_head], 0);
                pq_head  = (pq_head + 1) % QUEUE_DEPTH;
                pq_count = pq_count - 1;
            end
        end
        busy = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (sl_busy[s])
                busy++;
        // advance, stopping as soon as the job limit is hit
        for (int s = 0; s < SLOT_COUNT && !run_over; s++) begin
            if (sl_busy[s]) begin
                if (sl_age[s] != ELAPSED_MAX)
                    sl_age[s] = sl_age[s] + 1'b1;
                if (sl_age[s] >= sl_dur[s]) begin
                    sl_busy[s] = 1'b0;
                    if (done_jobs != COMPLETED_MAX)
                        done_jobs = done_jobs + 1'b1;
                    if (done_jobs >= limit_cfg)
                        run_over = 1'b1;
                    post(KIND_COMPLETE, sl_job[s], s, '0, 0);
                end
            end
        end
        if (!run_over)
            now_tick = now_tick + 1'b1;
        post(KIND_SUMMARY, '0, 0, '0, busy);
        want_q[$].last = 1'b1;
    endfunction

    // input acceptance feeds the model
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            dispatch_word('{cmd: s_cmd, id: s_job_id, dur: s_duration});
            in_taken = 1'b1;
        end
    end

    // input driver: new word only once the previous one is gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (send_q.size() == 0 || (!quiet && $urandom_range(99) < 19)) begin
                s_valid <= 1'b0;
            end else begin
                in_word_t w;
                w = send_q[0];
                send_q.delete(0);
                s_valid    <= 1'b1;
                s_cmd      <= w.cmd;
                s_job_id   <= w.id;
                s_duration <= w.dur;
            end
        end
    end

    // receiver ready, with one long hold-off on request
    int  hold_left;
    bit  hold_done;
    always @(negedge aclk) begin
        if (stall_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name,
                     want, got);
            errors++;
        end
    endfunction

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                $display("%0t unexpected word: expected none actual kind %0d job %0h",
                         $time, m_kind, m_out_job);
                errors++;
            end else begin
                res_word_t e;
                e = want_q[0];
                want_q.delete(0);
                check_field("kind", e.kind, m_kind);
                check_field("out_job", e.job, m_out_job);
                check_field("slot", e.slot, m_slot);
                check_field("wait_ticks", e.wt, m_wait_ticks);
                check_field("busy_slots", e.busy, m_busy_slots);
                check_field("done_res", e.done, m_done_res);
                check_field("last", e.last, m_last);
            end
        end
    end

    task automatic push_arrival(logic [JOB_W-1:0] id, logic [DUR_W-1:0] dur);
        send_q.insert(send_q.size(), '{cmd: CMD_ARRIVAL, id: id, dur: dur});
    endtask

    // ticks carry random junk in the ignored fields
    task automatic push_tick();
        send_q.insert(send_q.size(),
                      '{cmd: CMD_TICK, id: JOB_W'($urandom), dur: DUR_W'($urandom)});
    endtask

    // random traffic, mostly short jobs so the slots keep turning over
    task automatic push_mix(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 55)
                push_arrival(JOB_W'($urandom), ($urandom_range(99) < 85) ?
                             DUR_W'($urandom_range(0, 4)) :
                             DUR_W'($urandom_range(5, 40)));
            else
                push_tick();
        end
    endtask

    // everything sent, everything back, then let the block settle
    task automatic drain();
        wait (send_q.size() == 0 && !s_valid);
        wait (want_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx == CFG_SLOTS_IN_USE)
            slots_cfg = val[3:0];
        else
            limit_cfg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        quiet      = 1'b0;
        stall_req  = 1'b0;
        in_taken   = 1'b0;
        hold_left  = 0;
        hold_done  = 1'b0;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_addr   = CFG_SLOTS_IN_USE;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_cmd      = CMD_TICK;
        s_job_id   = '0;
        s_duration = '0;
        m_ready    = 1'b0;
        // model reset state
        pq_head = 0; pq_tail = 0; pq_count = 0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            sl_busy[s] = 1'b0;
            sl_job[s]  = '0;
            sl_dur[s]  = '0;
            sl_age[s]  = '0;
        end
        now_tick  = '0;
        done_jobs = '0;
        run_over  = 1'b0;
        slots_cfg = 4'd8;
        limit_cfg = 16'd80;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero and one tick jobs, id extremes, two jobs that
        // never finish and keep their slots busy for the rest of the run
        write_reg(CFG_JOB_LIMIT, 16'hFFFF);
        write_reg(CFG_SLOTS_IN_USE, 16'hFFF8);
        push_arrival(16'h0000, 24'd0);
        push_arrival(16'hFFFF, 24'd1);
        push_arrival(16'hA5A5, 24'd2);
        push_tick();
        push_arrival(16'h5A5A, 24'hFFFFFF);
        push_arrival(16'h1234, 24'h800000);
        push_tick();
        push_tick();
        push_arrival(16'h8001, 24'h555555 & 24'd3);
        push_tick();
        push_tick();
        push_tick();
        drain();

        // one slot in use, higher slots still busy and advancing
        write_reg(CFG_SLOTS_IN_USE, 16'd1);
        push_mix(30);
        drain();

        // no slot takes jobs: queue fills up and overflows
        write_reg(CFG_SLOTS_IN_USE, 16'd0);
        push_tick();
        push_tick();
        for (int i = 0; i < 68; i++)
            push_arrival(JOB_W'($urandom), DUR_W'($urandom_range(0, 3)));
        push_tick();
        drain();

        // over-range slot count saturates, queue drains
        write_reg(CFG_SLOTS_IN_USE, 16'd15);
        for (int i = 0; i < 50; i++)
            push_tick();
        drain();

        // no idling plus a long receiver hold-off so input backs up
        write_reg(CFG_SLOTS_IN_USE, 16'($urandom_range(2, 7)));
        quiet = 1'b1;
        stall_req = 1'b1;
        push_mix(50);
        drain();
        quiet = 1'b0;

        write_reg(CFG_SLOTS_IN_USE, 16'd8);
        push_mix(10);
        drain();

        // limit lowered below the completion count: ends at next completion,
        // mid tick, after which every word is ignored
        write_reg(CFG_JOB_LIMIT, 16'd1);
        push_arrival(JOB_W'($urandom), 24'd0);
        push_arrival(JOB_W'($urandom), 24'd0);
        push_tick();
        push_arrival(JOB_W'($urandom), 24'd0);
        push_tick();
        push_tick();
        drain();

        if (errors == 0)
            $display("fifo_slot_dispatcher_tb: clean");
        else
            $display("fifo_slot_dispatcher_tb: errors");
        $finish;
    end

endmodule
